[design/uqtp_pkg.sv]
// shared types, character codes and lookup functions for the request target parser
`default_nettype none

package uqtp_pkg;

    localparam int unsigned DEF_QUERY_CAPACITY = 64;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TGT   = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_BAD_PAGE  = 3'd4;
    localparam logic [2:0] ST_BAD_QUERY = 3'd5;

    localparam logic [3:0] PATH_LEN = 4'd12;

    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOW_Q   = 8'h71;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        logic        query_byte_valid;
        logic [7:0]  query_byte;
        logic        done_res;
        logic [2:0]  status;
        logic [31:0] page_value;
        logic        page_given;
        logic        query_given;
        logic [5:0]  decoded_count;
    } t_result;

    // "/api/signals"
    function automatic logic [7:0] path_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h2F;
            4'd1:    c = 8'h61;
            4'd2:    c = 8'h70;
            4'd3:    c = 8'h69;
            4'd4:    c = 8'h2F;
            4'd5:    c = 8'h73;
            4'd6:    c = 8'h69;
            4'd7:    c = 8'h67;
            4'd8:    c = 8'h6E;
            4'd9:    c = 8'h61;
            4'd10:   c = 8'h6C;
            4'd11:   c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "page"
    function automatic logic [7:0] page_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h70;
            2'd1:    c = 8'h61;
            2'd2:    c = 8'h67;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

    // bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/uqtp_core.sv]
// per-byte parse state and next-state logic, one byte per cycle while i_take is high
`default_nettype none

module uqtp_core
    import uqtp_pkg::*;
#(
    parameter int unsigned QUERY_CAPACITY = DEF_QUERY_CAPACITY
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam int unsigned CNT_W = (QUERY_CAPACITY > 2) ? $clog2(QUERY_CAPACITY) : 1;
    localparam logic [CNT_W:0] CAP_M1 = (CNT_W + 1)'(QUERY_CAPACITY - 1);

    typedef enum logic [2:0] {
        PH_PATH, PH_QMARK, PH_KEY, PH_PAGEV, PH_QV, PH_DRAIN
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_path_pos, n_path_pos;
    logic [2:0]       r_key_match, n_key_match;
    logic [2:0]       r_key_len, n_key_len;
    logic             r_seen_page, n_seen_page;
    logic             r_seen_q, n_seen_q;
    logic [31:0]      r_acc, n_acc;
    logic             r_val_len, n_val_len;
    logic [1:0]       r_pct, n_pct;
    logic [3:0]       r_hi, n_hi;
    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0]       r_err, n_err;

    logic [35:0] acc_next;
    logic [4:0]  hex;
    logic        is_digit;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, i_byte[3:0]};
    assign hex      = hex_decode(i_byte);

    always_comb begin
        logic       fail_now;
        logic [2:0] fail_code;
        logic       emit_try;
        logic [7:0] emit_val;
        logic       emit;
        fail_now    = 1'b0;
        fail_code   = ST_OK;
        emit_try    = 1'b0;
        emit_val    = 8'h00;
        emit        = 1'b0;
        n_phase     = r_phase;
        n_path_pos  = r_path_pos;
        n_key_match = r_key_match;
        n_key_len   = r_key_len;
        n_seen_page = r_seen_page;
        n_seen_q    = r_seen_q;
        n_acc       = r_acc;
        n_val_len   = r_val_len;
        n_pct       = r_pct;
        n_hi        = r_hi;
        n_count     = r_count;
        n_err       = r_err;

        case (r_phase)
            PH_PATH: begin
                if (r_path_pos < PATH_LEN && i_byte == path_char(r_path_pos)) begin
                    n_path_pos = r_path_pos + 4'd1;
                    if (n_path_pos == PATH_LEN) begin
                        if (!i_last) n_phase = PH_QMARK;
                    end else if (i_last) begin
                        fail_now = 1'b1; fail_code = ST_BAD_TGT;
                    end
                end else begin
                    fail_now = 1'b1; fail_code = ST_BAD_TGT;
                end
            end
            PH_QMARK: begin
                if (i_byte != CH_QMARK || i_last) begin
                    fail_now = 1'b1; fail_code = ST_BAD_TGT;
                end else begin
                    n_phase = PH_KEY; n_key_len = 3'd0; n_key_match = 3'd3;
                end
            end
            PH_KEY: begin
                if (i_byte == CH_AMP) begin
                    fail_now = 1'b1; fail_code = ST_BAD_TGT;
                end else if (i_byte == CH_EQUALS) begin
                    if (r_key_len == 3'd0) begin
                        fail_now = 1'b1; fail_code = ST_BAD_TGT;
                    end else if (r_key_match[0] && r_key_len == 3'd4) begin
                        if (r_seen_page) begin
                            fail_now = 1'b1; fail_code = ST_DUPLICATE;
                        end else begin
                            n_seen_page = 1'b1;
                            n_acc       = 32'd0;
                            n_val_len   = 1'b0;
                            n_phase     = PH_PAGEV;
                            if (i_last) begin
                                fail_now = 1'b1; fail_code = ST_BAD_PAGE;
                            end
                        end
                    end else if (r_key_match[1] && r_key_len == 3'd1) begin
                        if (r_seen_q) begin
                            fail_now = 1'b1; fail_code = ST_DUPLICATE;
                        end else begin
                            n_seen_q = 1'b1;
                            n_pct    = 2'd0;
                            n_phase  = PH_QV;
                        end
                    end else begin
                        fail_now = 1'b1; fail_code = ST_UNKNOWN;
                    end
                end else begin
                    if (!(r_key_len < 3'd4 && i_byte == page_char(r_key_len[1:0])))
                        n_key_match[0] = 1'b0;
                    if (!(r_key_len == 3'd0 && i_byte == CH_LOW_Q))
                        n_key_match[1] = 1'b0;
                    if (r_key_len < 3'd7) n_key_len = r_key_len + 3'd1;
                    if (i_last) begin
                        fail_now = 1'b1; fail_code = ST_BAD_TGT;
                    end
                end
            end
            PH_PAGEV: begin
                if (i_byte == CH_AMP) begin
                    if (!r_val_len) begin
                        fail_now = 1'b1; fail_code = ST_BAD_PAGE;
                    end else if (i_last) begin
                        fail_now = 1'b1; fail_code = ST_BAD_TGT;
                    end else begin
                        n_phase = PH_KEY; n_key_len = 3'd0; n_key_match = 3'd3;
                    end
                end else if (is_digit) begin
                    if (acc_next[35:32] != 4'd0) begin
                        fail_now = 1'b1; fail_code = ST_BAD_PAGE;
                    end else begin
                        n_acc     = acc_next[31:0];
                        n_val_len = 1'b1;
                    end
                end else begin
                    fail_now = 1'b1; fail_code = ST_BAD_PAGE;
                end
            end
            PH_QV: begin
                if (r_pct == 2'd0) begin
                    if (i_byte == CH_AMP) begin
                        if (i_last) begin
                            fail_now = 1'b1; fail_code = ST_BAD_TGT;
                        end else begin
                            n_phase = PH_KEY; n_key_len = 3'd0; n_key_match = 3'd3;
                        end
                    end else if (i_byte == CH_PERCENT) begin
                        n_pct = 2'd1;
                        if (i_last) begin
                            fail_now = 1'b1; fail_code = ST_BAD_QUERY;
                        end
                    end else begin
                        emit_try = 1'b1;
                        emit_val = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;
                    end
                end else if (!hex[4]) begin
                    fail_now = 1'b1; fail_code = ST_BAD_QUERY;
                end else if (r_pct == 2'd1) begin
                    n_hi  = hex[3:0];
                    n_pct = 2'd2;
                    if (i_last) begin
                        fail_now = 1'b1; fail_code = ST_BAD_QUERY;
                    end
                end else begin
                    n_pct    = 2'd0;
                    emit_try = 1'b1;
                    emit_val = {r_hi, hex[3:0]};
                end
            end
            default: begin
            end
        endcase

        // decoded byte must not be below space and the store must have room
        if (emit_try) begin
            if (emit_val < CH_SPACE || {1'b0, r_count} >= CAP_M1) begin
                fail_now = 1'b1; fail_code = ST_BAD_QUERY;
            end else begin
                emit    = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
        end

        if (fail_now) begin
            n_phase = PH_DRAIN;
            if (r_err == ST_OK) n_err = fail_code;
        end

        o_res_valid            = i_take && (emit || i_last);
        o_res.query_byte_valid = emit;
        o_res.query_byte       = emit ? emit_val : 8'h00;
        o_res.done_res         = i_last;
        o_res.status           = i_last ? n_err : ST_OK;
        o_res.page_value       = (i_last && n_err == ST_OK && n_seen_page) ? n_acc : 32'd0;
        o_res.page_given       = i_last && n_err == ST_OK && n_seen_page;
        o_res.query_given      = i_last && n_err == ST_OK && n_seen_q;
        o_res.decoded_count    = (i_last && n_err == ST_OK) ? 6'((CNT_W + 6)'(n_count)) : 6'd0;

        // every target ends with a return to the reset state
        if (i_last) begin
            n_phase     = PH_PATH;
            n_path_pos  = 4'd0;
            n_key_match = 3'd0;
            n_key_len   = 3'd0;
            n_seen_page = 1'b0;
            n_seen_q    = 1'b0;
            n_acc       = 32'd0;
            n_val_len   = 1'b0;
            n_pct       = 2'd0;
            n_hi        = 4'd0;
            n_count     = '0;
            n_err       = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PATH;
            r_path_pos  <= 4'd0;
            r_key_match <= 3'd0;
            r_key_len   <= 3'd0;
            r_seen_page <= 1'b0;
            r_seen_q    <= 1'b0;
            r_acc       <= 32'd0;
            r_val_len   <= 1'b0;
            r_pct       <= 2'd0;
            r_hi        <= 4'd0;
            r_count     <= '0;
            r_err       <= ST_OK;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_path_pos  <= n_path_pos;
            r_key_match <= n_key_match;
            r_key_len   <= n_key_len;
            r_seen_page <= n_seen_page;
            r_seen_q    <= n_seen_q;
            r_acc       <= n_acc;
            r_val_len   <= n_val_len;
            r_pct       <= n_pct;
            r_hi        <= n_hi;
            r_count     <= n_count;
            r_err       <= n_err;
        end
    end

endmodule

`default_nettype wire

[design/url_query_target_parser.sv]
// top level: request target parser with registered result and skid stage
//
//  channel | valid     | ready       | payload
//  in      | i_valid   | o_ready     | i_target_byte, i_last_byte
//  out     | o_valid   | i_ready     | o_query_byte_valid .. o_decoded_count
//
// one byte is taken per cycle while o_ready is high; its result word, if any, is
// registered in the result register (or in the skid entry if a word still waits
// there) and shows on the out channel; the rate is set by the parse step in uqtp_core
// a two-entry output buffer (result register plus skid) lets input go on while
// a word waits; o_ready drops only when both entries are full
// synchronous active-low reset returns the parser to path matching, no clearing pass
`default_nettype none

module url_query_target_parser
    import uqtp_pkg::*;
#(
    parameter int unsigned QUERY_CAPACITY = DEF_QUERY_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_target_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_query_byte_valid,
    output logic [7:0]       o_query_byte,
    output logic             o_done_res,
    output logic [2:0]       o_status,
    output logic [31:0]      o_page_value,
    output logic             o_page_given,
    output logic             o_query_given,
    output logic [5:0]       o_decoded_count
);

    logic    take;
    logic    res_valid;
    t_result res;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    out_fire;

    assign o_ready  = !r_skid_valid;
    assign take     = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;

    uqtp_core #(
        .QUERY_CAPACITY(QUERY_CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_target_byte),
        .i_last      (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_query_byte_valid = r_out.query_byte_valid;
    assign o_query_byte       = r_out.query_byte;
    assign o_done_res         = r_out.done_res;
    assign o_status           = r_out.status;
    assign o_page_value       = r_out.page_value;
    assign o_page_given       = r_out.page_given;
    assign o_query_given      = r_out.query_given;
    assign o_decoded_count    = r_out.decoded_count;

endmodule

`default_nettype wire

[design/uqtp_checker.sv]
// port-level checks on the result channel, bound to the top level
`default_nettype none

module uqtp_checker
    import uqtp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_query_byte_valid,
    input wire logic [7:0]  o_query_byte,
    input wire logic        o_done_res,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_page_value,
    input wire logic        o_page_given,
    input wire logic        o_query_given,
    input wire logic [5:0]  o_decoded_count
);

    // a waiting word is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    // every word carries a decoded byte or the final status
    a_useful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_query_byte_valid || o_done_res))
        else $error("empty result word");

    // a word that is not the end carries no summary
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> (o_status == ST_OK && !o_page_given
                                    && !o_query_given && o_decoded_count == 6'd0))
        else $error("summary fields set before the last byte");

    // failed target reports nothing parsed
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res && o_status != ST_OK |-> (o_page_value == 32'd0
            && !o_page_given && !o_query_given && o_decoded_count == 6'd0))
        else $error("fields set on a failed target");

    a_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_page_given |-> (o_page_value == 32'd0)
            && (o_query_byte_valid || o_query_byte == 8'h00))
        else $error("stale page value or query byte");

endmodule

bind url_query_target_parser uqtp_checker u_uqtp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_query_byte_valid (o_query_byte_valid),
    .o_query_byte       (o_query_byte),
    .o_done_res         (o_done_res),
    .o_status           (o_status),
    .o_page_value       (o_page_value),
    .o_page_given       (o_page_given),
    .o_query_given      (o_query_given),
    .o_decoded_count    (o_decoded_count)
);

`default_nettype wire
